[design/ir90_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ir90_pkg: shared types and constants of the 90-degree image rotator
// Field widths, register indexes, request and status codes, and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ir90_pkg;

   localparam int DEF_MAX_WIDTH  = 64;
   localparam int DEF_MAX_HEIGHT = 64;

   localparam int DIM_W      = 7;
   localparam int PITCH_W    = 13;
   localparam int PIX_W      = 8;
   localparam int DADDR_W    = 18;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [DIM_W-1:0]   RST_IMG_WIDTH  = 7'd64;
   localparam logic [DIM_W-1:0]   RST_IMG_HEIGHT = 7'd64;
   localparam logic               RST_ROTATE_CCW = 1'b0;
   localparam logic [PITCH_W-1:0] RST_DST_PITCH  = 13'd64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMG_WIDTH  = 2'd0,
      CSR_IMG_HEIGHT = 2'd1,
      CSR_ROTATE_CCW = 2'd2,
      CSR_DST_PITCH  = 2'd3
   } csr_idx_type;

   localparam logic REQ_STORE       = 1'b0;
   localparam logic REQ_FETCH       = 1'b1;
   localparam logic FETCH_OK        = 1'b0;
   localparam logic FETCH_NOT_READY = 1'b1;

   typedef struct packed {
      logic store;
      logic calc;
      logic read;
      logic emit_pix;
      logic emit_nr;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_fetch;
      logic frame_full;
      logic out_free;
   } dp_status_type;

   // saturate a dimension register into 1..maxv
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
      logic [DIM_W-1:0] res;
      begin
         if (v == '0) begin
            res = DIM_W'(1);
         end else if (int'(v) > maxv) begin
            res = DIM_W'(maxv);
         end else begin
            res = v;
         end
         return res;
      end
   endfunction

endpackage
`default_nettype wire

[design/ir90_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ir90 channel interfaces
// Request, response and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ir90_req_if;
   import ir90_pkg::*;
   logic             valid;
   logic             ready;
   logic             req_type;
   logic [PIX_W-1:0] pixel_in;
   modport source (output valid, output req_type, output pixel_in, input ready);
   modport sink   (input valid, input req_type, input pixel_in, output ready);
endinterface

interface ir90_rsp_if;
   import ir90_pkg::*;
   logic               valid;
   logic               ready;
   logic [PIX_W-1:0]   pixel_out;
   logic [DADDR_W-1:0] dst_address;
   logic               last_pixel;
   logic               fetch_status;
   modport source (output valid, output pixel_out, output dst_address, output last_pixel,
                   output fetch_status, input ready);
   modport sink   (input valid, input pixel_out, input dst_address, input last_pixel,
                   input fetch_status, output ready);
endinterface

interface ir90_csr_if;
   import ir90_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[design/image_rotate_90.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// image_rotate_90: frame-store 90-degree image rotator
// Loads a source frame pixel by pixel and reads it back rotated.
// ----------------------------------------------------------------------------
// Usage:
//   req_if  : store (req_type 0, pixel_in) or fetch (req_type 1) requests.
//   rsp_if  : one beat per fetch: pixel_out, dst_address, last_pixel and
//             fetch_status (1 while the frame is not yet fully loaded).
//   csr_if  : register writes, index 0 width, 1 height, 2 rotate_ccw,
//             3 dst_pitch; always ready, write only while the block is idle.
// Timing:
//   Stores stream at one beat per cycle while no fetch is in progress.
//   A fetch of a loaded frame steps through address multiply, frame-store
//   read and output load, which loads the response register; the next
//   request is taken only after that load, so fetches do not overlap. A
//   fetch before the frame is full goes straight to the output step. The
//   frame store's registered read port is why a fetch needs a read step.
//   The response register decouples the sides: a new request is accepted
//   while a response waits; a fetch then holds in its output step, and
//   blocks further requests, until the register frees.
// Reset clears the load count, scan position and response valid and
// restores register defaults; frame-store contents are left as they are.
// ----------------------------------------------------------------------------
module image_rotate_90 #(
   parameter int MAX_WIDTH  = ir90_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = ir90_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ir90_req_if.sink   req_if,
   ir90_rsp_if.source rsp_if,
   ir90_csr_if.sink   csr_if
);
   import ir90_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type sts;
   logic          req_ready;

   ir90_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ir90_dpath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_type (req_if.req_type),
      .pixel_in (req_if.pixel_in),
      .rsp_if   (rsp_if),
      .csr_if   (csr_if),
      .cmd      (cmd),
      .sts      (sts)
   );

   assign req_if.ready = req_ready;

`ifndef SYNTHESIS
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.store, cmd.calc, cmd.read, cmd.emit_pix, cmd.emit_nr}))
      else $error("ir90: more than one datapath command at once");

   a_calc_then_read: assert property (@(posedge clock) disable iff (reset)
      cmd.calc |=> cmd.read)
      else $error("ir90: frame-store read did not follow address calculation");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_pix || cmd.emit_nr) |-> sts.out_free)
      else $error("ir90: response loaded while output register busy");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(cmd.emit_pix || cmd.emit_nr))
      else $error("ir90: response beat without an emit command");
`endif

endmodule
`default_nettype wire

[design/ir90_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ir90_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ir90_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

[design/ir90_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ir90_ctrl: request sequencer
// Accepts requests; steps a full-frame fetch through address, read and emit.
// ----------------------------------------------------------------------------
module ir90_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire ir90_pkg::dp_status_type sts,
   output ir90_pkg::ctrl_cmd_type       cmd
);
   import ir90_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_READ,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      nr_ff, nr_in;

   always_comb begin
      state_in = state_ff;
      nr_in    = nr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && sts.is_fetch) begin
               nr_in    = !sts.frame_full;
               state_in = sts.frame_full ? ST_CALC : ST_EMIT;
            end
         end
         ST_CALC: state_in = ST_READ;
         ST_READ: state_in = ST_EMIT;
         ST_EMIT: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         nr_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         nr_ff    <= nr_in;
      end
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign cmd.store    = (state_ff == ST_IDLE) && req_valid && !sts.is_fetch;
   assign cmd.calc     = (state_ff == ST_CALC);
   assign cmd.read     = (state_ff == ST_READ);
   assign cmd.emit_pix = (state_ff == ST_EMIT) && sts.out_free && !nr_ff;
   assign cmd.emit_nr  = (state_ff == ST_EMIT) && sts.out_free && nr_ff;

endmodule
`default_nettype wire

[design/ir90_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ir90_dpath: rotator datapath
// Registers, frame store, load and scan counters, source index and
// destination address arithmetic, and the response output register.
// ----------------------------------------------------------------------------
module ir90_dpath #(
   parameter int MAX_WIDTH  = ir90_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = ir90_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_type,
   input  wire logic [ir90_pkg::PIX_W-1:0]   pixel_in,
   ir90_rsp_if.source                        rsp_if,
   ir90_csr_if.sink                          csr_if,
   input  wire ir90_pkg::ctrl_cmd_type       cmd,
   output ir90_pkg::dp_status_type           sts
);
   import ir90_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int ROW_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int COL_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int RC_W  = (ROW_W > COL_W) ? ROW_W : COL_W;
   localparam int CMP_W = ((RC_W > DIM_W) ? RC_W : DIM_W) + 1;
   localparam int TOT_W = 2 * DIM_W;
   localparam int LC_W  = (CNT_W > TOT_W) ? CNT_W : TOT_W;

   logic [DIM_W-1:0]   img_width_ff, img_width_in;
   logic [DIM_W-1:0]   img_height_ff, img_height_in;
   logic               rotate_ccw_ff, rotate_ccw_in;
   logic [PITCH_W-1:0] dst_pitch_ff, dst_pitch_in;

   logic [CNT_W-1:0]   load_count_ff, load_count_in;
   logic [ROW_W-1:0]   out_row_ff, out_row_in;
   logic [COL_W-1:0]   out_col_ff, out_col_in;
   logic               frame_full_ff, frame_full_in;

   logic [IDX_W-1:0]   src_ff, src_in;
   logic [DADDR_W-1:0] addr_ff, addr_in;
   logic               last_ff, last_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]   rsp_pixel_ff;
   logic [DADDR_W-1:0] rsp_addr_ff;
   logic               rsp_last_ff;
   logic               rsp_status_ff;

   logic [DIM_W-1:0]   w, h;
   logic [TOT_W-1:0]   total;
   logic [CNT_W-1:0]   load_inc;
   logic               store_we;
   logic [IDX_W-1:0]   sy, sx, lin;
   logic [CMP_W-1:0]   r_ext, c_ext, w_ext, h_ext, col_inc;
   logic               col_wrap;
   logic [PIX_W-1:0]   ram_rdata;

   assign w        = clamp_dim(img_width_ff, MAX_WIDTH);
   assign h        = clamp_dim(img_height_ff, MAX_HEIGHT);
   assign total    = TOT_W'(w) * TOT_W'(h);
   assign load_inc = load_count_ff + CNT_W'(1);
   assign store_we = cmd.store && !frame_full_ff;

   // source position of the current destination pixel
   always_comb begin
      if (rotate_ccw_ff) begin
         sy = IDX_W'(out_col_ff);
         sx = IDX_W'(w) - IDX_W'(1) - IDX_W'(out_row_ff);
      end else begin
         sy = IDX_W'(h) - IDX_W'(1) - IDX_W'(out_col_ff);
         sx = IDX_W'(out_row_ff);
      end
   end

   assign lin     = sy * IDX_W'(w) + sx;
   assign r_ext   = CMP_W'(out_row_ff);
   assign c_ext   = CMP_W'(out_col_ff);
   assign w_ext   = CMP_W'(w);
   assign h_ext   = CMP_W'(h);
   assign col_inc = c_ext + CMP_W'(1);
   assign col_wrap = (col_inc >= h_ext);

   always_comb begin
      src_in  = ({1'b0, lin} >= (IDX_W + 1)'(DEPTH)) ? lin - IDX_W'(DEPTH) : lin;
      addr_in = DADDR_W'(out_row_ff) * DADDR_W'(dst_pitch_ff) + DADDR_W'(out_col_ff);
      last_in = (col_wrap && (r_ext + CMP_W'(1) >= w_ext)) || (r_ext >= w_ext);
   end

   // counters and frame state
   always_comb begin
      load_count_in = load_count_ff;
      out_row_in    = out_row_ff;
      out_col_in    = out_col_ff;
      frame_full_in = frame_full_ff;
      if (store_we) begin
         load_count_in = load_inc;
         if (LC_W'(load_inc) >= LC_W'(total)) begin
            frame_full_in = 1'b1;
         end
      end else if (cmd.calc) begin
         if (last_in) begin
            load_count_in = '0;
            out_row_in    = '0;
            out_col_in    = '0;
            frame_full_in = 1'b0;
         end else if (col_wrap) begin
            out_col_in = '0;
            out_row_in = out_row_ff + ROW_W'(1);
         end else begin
            out_col_in = COL_W'(col_inc);
         end
      end
   end

   // register writes
   always_comb begin
      img_width_in  = img_width_ff;
      img_height_in = img_height_ff;
      rotate_ccw_in = rotate_ccw_ff;
      dst_pitch_in  = dst_pitch_ff;
      if (csr_if.valid) begin
         unique case (csr_idx_type'(csr_if.index))
            CSR_IMG_WIDTH:  img_width_in  = csr_if.data[DIM_W-1:0];
            CSR_IMG_HEIGHT: img_height_in = csr_if.data[DIM_W-1:0];
            CSR_ROTATE_CCW: rotate_ccw_in = csr_if.data[0];
            CSR_DST_PITCH:  dst_pitch_in  = csr_if.data[PITCH_W-1:0];
         endcase
      end
   end

   assign rsp_valid_in = (cmd.emit_pix || cmd.emit_nr) ? 1'b1 :
                         (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         img_width_ff  <= RST_IMG_WIDTH;
         img_height_ff <= RST_IMG_HEIGHT;
         rotate_ccw_ff <= RST_ROTATE_CCW;
         dst_pitch_ff  <= RST_DST_PITCH;
         load_count_ff <= '0;
         out_row_ff    <= '0;
         out_col_ff    <= '0;
         frame_full_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         img_width_ff  <= img_width_in;
         img_height_ff <= img_height_in;
         rotate_ccw_ff <= rotate_ccw_in;
         dst_pitch_ff  <= dst_pitch_in;
         load_count_ff <= load_count_in;
         out_row_ff    <= out_row_in;
         out_col_ff    <= out_col_in;
         frame_full_ff <= frame_full_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         src_ff  <= src_in;
         addr_ff <= addr_in;
         last_ff <= last_in;
      end
      if (cmd.emit_pix) begin
         rsp_pixel_ff  <= ram_rdata;
         rsp_addr_ff   <= addr_ff;
         rsp_last_ff   <= last_ff;
         rsp_status_ff <= FETCH_OK;
      end else if (cmd.emit_nr) begin
         rsp_pixel_ff  <= '0;
         rsp_addr_ff   <= '0;
         rsp_last_ff   <= 1'b0;
         rsp_status_ff <= FETCH_NOT_READY;
      end
   end

   ir90_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_frame_store (
      .clock (clock),
      .we    (store_we),
      .waddr (load_count_ff[IDX_W-1:0]),
      .wdata (pixel_in),
      .re    (cmd.read),
      .raddr (src_ff),
      .rdata (ram_rdata)
   );

   assign csr_if.ready       = 1'b1;
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.pixel_out    = rsp_pixel_ff;
   assign rsp_if.dst_address  = rsp_addr_ff;
   assign rsp_if.last_pixel   = rsp_last_ff;
   assign rsp_if.fetch_status = rsp_status_ff;

   assign sts.is_fetch   = (req_type == REQ_FETCH);
   assign sts.frame_full = frame_full_ff;
   assign sts.out_free   = !rsp_valid_ff || rsp_if.ready;

endmodule
`default_nettype wire
